@@ rtl/core/hpt_pkg.sv @@
// Shared constants and types for the homogeneous point transform.
`timescale 1ns / 1ps
package hpt_pkg;

	localparam int HPT_FRAC_BITS = 16;
	localparam int HPT_NUM_REGS  = 8;
	localparam int HPT_CFG_IDX_W = 4;
	localparam int HPT_CFG_DAT_W = 64;

	// command codes
	localparam logic CMD_DIVIDE = 1'b0;
	localparam logic CMD_RAW    = 1'b1;

	// sideband that travels alongside the divider stages
	typedef struct packed {
		logic             last;
		logic             sat;
		logic             div;
		logic [2:0]       neg;
		logic [31:0]      w;
		logic [2:0][31:0] xyz;
	} hpt_side_t;

endpackage

@@ rtl/core/hpt_if.sv @@
// Valid/ready channel interfaces for points, results and register writes.
`timescale 1ns / 1ps
interface hpt_pt_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;
	logic [31:0] coord_w;
	logic        last_point;
	modport source (output valid, command, coord_x, coord_y, coord_z, coord_w, last_point,
		input ready);
	modport sink (input valid, command, coord_x, coord_y, coord_z, coord_w, last_point,
		output ready);
endinterface

interface hpt_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [31:0] out_w;
	logic        saturated;
	logic        last_out;
	modport source (output valid, out_x, out_y, out_z, out_w, saturated, last_out,
		input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, saturated, last_out,
		output ready);
endinterface

interface hpt_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/hpt_div_pipe.sv @@
// Pipelined restoring divider: three quotients over one shared divisor, one bit a stage.
`timescale 1ns / 1ps
module hpt_div_pipe #(
	parameter int FRAC_BITS = hpt_pkg::HPT_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [31:0]              den,
	input  logic [32+FRAC_BITS-1:0]  num [3],
	input  hpt_pkg::hpt_side_t       side_in,
	output logic                     out_valid,
	output logic [32+FRAC_BITS-1:0]  quo [3],
	output hpt_pkg::hpt_side_t       side_out
);
	import hpt_pkg::*;

	localparam int ND = 32 + FRAC_BITS;

	logic            vld_sk  [ND+1];
	logic [31:0]     den_sk  [ND+1];
	logic [31:0]     rem_sk  [ND+1][3];
	logic [ND-1:0]   num_sk  [ND+1][3];
	hpt_side_t       side_sk [ND+1];

	always_comb begin
		vld_sk[0]  = in_valid;
		den_sk[0]  = den;
		side_sk[0] = side_in;
		for (int c = 0; c < 3; c++) begin
			rem_sk[0][c] = '0;
			num_sk[0][c] = num[c];
		end
	end

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic [31:0]   rem_d [3];
		logic [ND-1:0] num_d [3];

		always_comb begin
			logic [32:0] trial;
			logic        ge;
			for (int c = 0; c < 3; c++) begin
				trial = {rem_sk[k][c], num_sk[k][c][ND-1]};
				ge    = trial >= {1'b0, den_sk[k]};
				rem_d[c] = ge ? 32'(trial - {1'b0, den_sk[k]}) : trial[31:0];
				num_d[c] = {num_sk[k][c][ND-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				den_sk[k+1]  <= den_sk[k];
				side_sk[k+1] <= side_sk[k];
				for (int c = 0; c < 3; c++) begin
					rem_sk[k+1][c] <= rem_d[c];
					num_sk[k+1][c] <= num_d[c];
				end
			end
		end
	end

	assign out_valid = vld_sk[ND];
	assign side_out  = side_sk[ND];
	always_comb begin
		for (int c = 0; c < 3; c++) quo[c] = num_sk[ND][c];
	end

endmodule

@@ rtl/core/homogeneous_point_transform.sv @@
// Top level of the pipelined 4x4 homogeneous point transform.
//
// Usage
//   pt_in  : one transaction per point (command, coord_x..coord_w, last_point).
//   pt_out : one transaction per point (out_x..out_w, saturated, last_out).
//   cfg    : register writes, index 0..7 selects a matrix register pair of
//            Q entries; indexes 8 and above are dropped. Always ready.
//   Points are row vectors times the matrix. Command 0 forces w to 1.0 and
//   divides x, y and z by the product w unless it is 0 or 1.0.
// Pipeline (Q16.16 by default): five arithmetic stages, one divider stage
//   per quotient bit (32 + FRAC_BITS), and the output register.
// Throughput: one point per cycle while no shown result is stalled; every stage holds one point.
// Reset: arst_n clears all valid bits and loads the identity matrix.
// Stall: while a result is shown and not taken every stage holds and
//   pt_in.ready drops, bubbles or not; one point per cycle resumes in the
//   cycle the result is taken.
`timescale 1ns / 1ps
module homogeneous_point_transform #(
	parameter int FRAC_BITS = hpt_pkg::HPT_FRAC_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	hpt_cfg_if.sink   cfg,
	hpt_pt_if.sink    pt_in,
	hpt_res_if.source pt_out
);
	import hpt_pkg::*;

	localparam int ND = 32 + FRAC_BITS;
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
	localparam logic [65:0] HALF = 66'(1) << (FRAC_BITS - 1);

	// matrix registers, row r holds cols01 at 2r and cols23 at 2r+1
	logic [63:0] mat_q [HPT_NUM_REGS];

	// advance the whole pipeline unless the shown result is stalled
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic              raw_s1, last_s1;
	logic signed [31:0] pt_s1 [4];
	logic              raw_s2, last_s2;
	logic signed [63:0] prod_s2 [4][4];
	logic              raw_s3, last_s3;
	logic signed [64:0] pair_s3 [4][2];
	logic              raw_s4, last_s4;
	logic signed [65:0] sum_s4 [4];
	logic              raw_s5, last_s5, sat_s5;
	logic signed [31:0] res_s5 [4];

	logic [31:0] res_s6 [4];
	logic        sat_s6, last_s6;

	// --- register writes ---
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= {32'd0, ONE};
			mat_q[1] <= '0;
			mat_q[2] <= {ONE, 32'd0};
			mat_q[3] <= '0;
			mat_q[4] <= '0;
			mat_q[5] <= {32'd0, ONE};
			mat_q[6] <= '0;
			mat_q[7] <= {ONE, 32'd0};
		end else if (cfg.valid && cfg.index < HPT_CFG_IDX_W'(HPT_NUM_REGS)) begin
			mat_q[cfg.index[2:0]] <= cfg.data;
		end
	end

	assign adv         = !v_s6 || pt_out.ready;
	assign pt_in.ready = adv;

	// --- valid chain ---
	logic v_div;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_div;
		end
	end

	// --- stage 1: capture the point, force w to 1.0 for the divide command ---
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1   <= pt_in.command == CMD_RAW;
			last_s1  <= pt_in.last_point;
			pt_s1[0] <= pt_in.coord_x;
			pt_s1[1] <= pt_in.coord_y;
			pt_s1[2] <= pt_in.coord_z;
			pt_s1[3] <= (pt_in.command == CMD_RAW) ? pt_in.coord_w : ONE;
		end
	end

	// --- stage 2: sixteen products, coordinate r times entry M[r][j] ---
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s2  <= raw_s1;
			last_s2 <= last_s1;
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s2[r][j] <= pt_s1[r] *
						$signed(mat_q[2*r + j/2][32*(j%2) +: 32]);
				end
			end
		end
	end

	// --- stage 3: pairwise sums ---
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s3  <= raw_s2;
			last_s3 <= last_s2;
			for (int j = 0; j < 4; j++) begin
				pair_s3[j][0] <= 65'(prod_s2[0][j]) + 65'(prod_s2[1][j]);
				pair_s3[j][1] <= 65'(prod_s2[2][j]) + 65'(prod_s2[3][j]);
			end
		end
	end

	// --- stage 4: exact sum, round half up, scale down ---
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s4  <= raw_s3;
			last_s4 <= last_s3;
			for (int j = 0; j < 4; j++) begin
				sum_s4[j] <= (66'(pair_s3[j][0]) + 66'(pair_s3[j][1]) + $signed(HALF))
					>>> FRAC_BITS;
			end
		end
	end

	// --- stage 5: clamp to 32 bits ---
	always_ff @(posedge clk) begin
		logic any_sat;
		if (adv) begin
			any_sat = 1'b0;
			for (int j = 0; j < 4; j++) begin
				if (sum_s4[j][65:31] != {35{sum_s4[j][65]}}) begin
					any_sat   = 1'b1;
					res_s5[j] <= sum_s4[j][65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				end else begin
					res_s5[j] <= sum_s4[j][31:0];
				end
			end
			sat_s5  <= any_sat;
			raw_s5  <= raw_s4;
			last_s5 <= last_s4;
		end
	end

	// --- divider feed: magnitudes and signs ---
	logic [ND-1:0] num_d [3];
	logic [31:0]   den_d;
	hpt_side_t     side_d, side_q;
	logic [ND-1:0] quo [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_d[c] = {(res_s5[c][31] ? 32'(-res_s5[c]) : 32'(res_s5[c])),
				{FRAC_BITS{1'b0}}};
			side_d.neg[c] = res_s5[c][31] ^ res_s5[3][31];
			side_d.xyz[c] = res_s5[c];
		end
		den_d       = res_s5[3][31] ? 32'(-res_s5[3]) : 32'(res_s5[3]);
		side_d.last = last_s5;
		side_d.sat  = sat_s5;
		side_d.div  = !raw_s5 && res_s5[3] != 32'sd0 && res_s5[3] != $signed(ONE);
		side_d.w    = res_s5[3];
	end

	hpt_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s5),
		.den       (den_d),
		.num       (num_d),
		.side_in   (side_d),
		.out_valid (v_div),
		.quo       (quo),
		.side_out  (side_q)
	);

	// --- output stage: sign, clamp the quotients, or pass the product ---
	always_ff @(posedge clk) begin
		logic any_sat;
		if (adv) begin
			any_sat = side_q.sat;
			for (int c = 0; c < 3; c++) begin
				if (!side_q.div) begin
					res_s6[c] <= side_q.xyz[c];
				end else if (side_q.neg[c]) begin
					if (quo[c][ND-1:32] != '0 || (quo[c][31] && quo[c][30:0] != '0)) begin
						any_sat   = 1'b1;
						res_s6[c] <= 32'h8000_0000;
					end else begin
						res_s6[c] <= 32'(-quo[c][31:0]);
					end
				end else begin
					if (quo[c][ND-1:31] != '0) begin
						any_sat   = 1'b1;
						res_s6[c] <= 32'h7fff_ffff;
					end else begin
						res_s6[c] <= quo[c][31:0];
					end
				end
			end
			res_s6[3] <= side_q.w;
			sat_s6    <= any_sat;
			last_s6   <= side_q.last;
		end
	end

	assign pt_out.valid     = v_s6;
	assign pt_out.out_x     = res_s6[0];
	assign pt_out.out_y     = res_s6[1];
	assign pt_out.out_z     = res_s6[2];
	assign pt_out.out_w     = res_s6[3];
	assign pt_out.saturated = sat_s6;
	assign pt_out.last_out  = last_s6;

endmodule

@@ rtl/core/hpt_checker.sv @@
// Port-level checks for the point transform, bound to the top level.
`timescale 1ns / 1ps
module hpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready
);
	logic [7:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result without a pending point");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pt_in.valid),
	.in_ready  (pt_in.ready),
	.out_valid (pt_out.valid),
	.out_ready (pt_out.ready),
	.cfg_ready (cfg.ready)
);

@@ sim/tb.sv @@
// Self-checking testbench for the homogeneous point transform.
`timescale 1ns / 1ps
module tb;
	import hpt_pkg::*;

	// one point and one transformed result as they cross the channels
	typedef struct packed {
		logic        command;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic        last;
	} point_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic        sat;
		logic        last;
	} vertex_t;

	localparam int        LATENCY     = 38 + HPT_FRAC_BITS;
	localparam int        CYCLE_LIMIT = 400000;
	localparam logic [31:0] FX_ONE    = 32'sd1 <<< HPT_FRAC_BITS;
	localparam logic [31:0] FX_MINUS1 = -(32'sd1 <<< HPT_FRAC_BITS);
	localparam logic [31:0] S32_MAX   = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN   = 32'h8000_0000;

	logic clk;
	logic arst_n;

	hpt_cfg_if cfg ();
	hpt_pt_if  pt_in ();
	hpt_res_if pt_out ();

	homogeneous_point_transform dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.pt_in  (pt_in.sink),
		.pt_out (pt_out.source)
	);

	// Matrix as the block should hold it, points waiting to be sent and
	// results waiting to come back.
	logic [63:0] matrix_regs [HPT_NUM_REGS];
	point_t      points_pending [$];
	vertex_t     vertices_due [$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          error_count;
	int          cycle_count;

	// Row-vector times matrix, with rounding, clamping and the optional
	// perspective divide.
	function automatic vertex_t transform_point(point_t p);
		logic signed [67:0] acc;
		logic signed [67:0] pa;
		logic signed [67:0] pb;
		logic signed [31:0] coord [4];
		logic signed [31:0] comp [4];
		logic [63:0]        reg_val;
		longint             num;
		longint             quo;
		logic               sat;
		vertex_t            v;
		sat = 1'b0;
		coord[0] = p.x;
		coord[1] = p.y;
		coord[2] = p.z;
		coord[3] = (p.command == CMD_RAW) ? p.w : FX_ONE;
		for (int j = 0; j < 4; j++) begin
			acc = '0;
			for (int r = 0; r < 4; r++) begin
				reg_val = matrix_regs[r * 2 + j / 2];
				pa = coord[r];
				pb = $signed(j[0] ? reg_val[63:32] : reg_val[31:0]);
				acc += pa * pb;
			end
			// round to nearest, ties towards plus infinity
			acc = (acc + (68'sd1 <<< (HPT_FRAC_BITS - 1))) >>> HPT_FRAC_BITS;
			if (acc > 68'sh7fff_ffff) begin
				comp[j] = S32_MAX;
				sat = 1'b1;
			end else if (acc < -68'sh8000_0000) begin
				comp[j] = S32_MIN;
				sat = 1'b1;
			end else begin
				comp[j] = acc[31:0];
			end
		end
		// divide only when w is neither zero nor exactly one
		if (p.command == CMD_DIVIDE && comp[3] != 0 && comp[3] != $signed(FX_ONE)) begin
			for (int j = 0; j < 3; j++) begin
				num = longint'(comp[j]) <<< HPT_FRAC_BITS;
				quo = num / longint'(comp[3]);
				if (quo > longint'(32'sh7fff_ffff)) begin
					comp[j] = S32_MAX;
					sat = 1'b1;
				end else if (quo < -longint'(64'sh8000_0000)) begin
					comp[j] = S32_MIN;
					sat = 1'b1;
				end else begin
					comp[j] = quo[31:0];
				end
			end
		end
		v.x = comp[0];
		v.y = comp[1];
		v.z = comp[2];
		v.w = comp[3];
		v.sat = sat;
		v.last = p.last;
		return v;
	endfunction

	// Mostly small magnitudes so that products stay in range, sometimes the
	// full 32-bit range to hit clamping.
	function automatic logic [31:0] rand_fx();
		case ($urandom_range(0, 9))
			0, 1, 2: rand_fx = $urandom;
			3: rand_fx = ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
			default: rand_fx = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.command = 1'($urandom_range(0, 1));
		p.x = rand_fx();
		p.y = rand_fx();
		p.z = rand_fx();
		p.w = rand_fx();
		p.last = 1'($urandom_range(0, 1));
		return p;
	endfunction

	function automatic point_t mk_point(logic cmd, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] w, logic last);
		point_t p;
		p.command = cmd;
		p.x = x;
		p.y = y;
		p.z = z;
		p.w = w;
		p.last = last;
		return p;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: present the head of the pending queue, hold it until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_in.valid      <= 1'b0;
			pt_in.command    <= CMD_DIVIDE;
			pt_in.coord_x    <= '0;
			pt_in.coord_y    <= '0;
			pt_in.coord_z    <= '0;
			pt_in.coord_w    <= '0;
			pt_in.last_point <= 1'b0;
		end else begin
			automatic logic taken = pt_in.valid && pt_in.ready;
			if (taken) begin
				vertices_due.push_back(transform_point(points_pending[0]));
				void'(points_pending.pop_front());
			end
			if (pt_in.valid && !taken) begin
				// hold the transaction on the wires
			end else if (points_pending.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				pt_in.valid      <= 1'b1;
				pt_in.command    <= points_pending[0].command;
				pt_in.coord_x    <= points_pending[0].x;
				pt_in.coord_y    <= points_pending[0].y;
				pt_in.coord_z    <= points_pending[0].z;
				pt_in.coord_w    <= points_pending[0].w;
				pt_in.last_point <= points_pending[0].last;
			end else begin
				pt_in.valid <= 1'b0;
			end
		end
	end

	// Monitor: stall at random, compare each result with the oldest due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_out.ready <= 1'b0;
		end else begin
			if (pt_out.valid && pt_out.ready) begin
				if (vertices_due.size() == 0) begin
					$error("unexpected result x=%h y=%h z=%h w=%h",
						pt_out.out_x, pt_out.out_y, pt_out.out_z, pt_out.out_w);
					error_count++;
				end else begin
					automatic vertex_t e = vertices_due.pop_front();
					if (pt_out.out_x !== e.x) begin
						$error("out_x expected %h got %h", e.x, pt_out.out_x);
						error_count++;
					end
					if (pt_out.out_y !== e.y) begin
						$error("out_y expected %h got %h", e.y, pt_out.out_y);
						error_count++;
					end
					if (pt_out.out_z !== e.z) begin
						$error("out_z expected %h got %h", e.z, pt_out.out_z);
						error_count++;
					end
					if (pt_out.out_w !== e.w) begin
						$error("out_w expected %h got %h", e.w, pt_out.out_w);
						error_count++;
					end
					if (pt_out.saturated !== e.sat) begin
						$error("saturated expected %b got %b", e.sat, pt_out.saturated);
						error_count++;
					end
					if (pt_out.last_out !== e.last) begin
						$error("last_out expected %b got %b", e.last, pt_out.last_out);
						error_count++;
					end
				end
			end
			pt_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Write one register; mirror it in the expected matrix once it is taken.
	task automatic write_reg(logic [3:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx < HPT_NUM_REGS)
			matrix_regs[idx[2:0]] = value;
	endtask

	// Wait until every sent point has come back, plus the pipeline depth.
	task automatic drain();
		while (points_pending.size() != 0 || vertices_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		repeat (n) points_pending.push_back(rand_point());
	endtask

	function automatic logic [63:0] rand_pair();
		return {rand_fx(), rand_fx()};
	endfunction

	initial begin
		cfg.valid      = 1'b0;
		cfg.index      = '0;
		cfg.data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		cycle_count    = 0;
		// identity after reset
		matrix_regs[0] = 64'(FX_ONE);
		matrix_regs[1] = '0;
		matrix_regs[2] = 64'(FX_ONE) << 32;
		matrix_regs[3] = '0;
		matrix_regs[4] = '0;
		matrix_regs[5] = 64'(FX_ONE);
		matrix_regs[6] = '0;
		matrix_regs[7] = 64'(FX_ONE) << 32;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Identity matrix: field extremes through both commands.
		points_pending.push_back(mk_point(CMD_DIVIDE, S32_MAX, S32_MIN, 0, S32_MAX, 1'b1));
		points_pending.push_back(mk_point(CMD_DIVIDE, FX_ONE, FX_MINUS1, 1, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_RAW, S32_MAX, S32_MIN, 32'hffff_ffff,
			S32_MIN, 1'b1));
		points_pending.push_back(mk_point(CMD_RAW, 1, 2, 3, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_RAW, 0, 0, 0, FX_ONE, 1'b0));
		points_pending.push_back(mk_point(CMD_RAW, FX_ONE, FX_ONE, FX_ONE, 32'h0000_8000, 1'b1));
		points_pending.push_back(mk_point(CMD_RAW, 32'h0001_0000, 32'hffff_0000,
			32'h0000_8000, FX_MINUS1, 1'b0));
		drain();

		// A write to an unused index must be dropped.
		write_reg(4'd8, 64'hdead_beef_dead_beef);
		write_reg(4'd15, '1);
		// Perspective matrix: w takes z, so the divide is steered by z.
		write_reg(4'd5, {FX_ONE, FX_ONE});
		write_reg(4'd7, '0);
		points_pending.push_back(mk_point(CMD_DIVIDE, FX_ONE, FX_ONE, 0, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_DIVIDE, FX_ONE, FX_ONE, FX_ONE, 0, 1'b1));
		points_pending.push_back(mk_point(CMD_DIVIDE, S32_MAX, S32_MIN, 1, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_DIVIDE, 32'h0003_0000, 32'hfffd_0000,
			32'h0002_0000, 0, 1'b1));
		points_pending.push_back(mk_point(CMD_DIVIDE, 32'h0005_0000, 32'h0001_0000,
			FX_MINUS1, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_DIVIDE, 7, 32'hffff_fff9,
			32'h0003_0000, 0, 1'b0));
		points_pending.push_back(mk_point(CMD_DIVIDE, S32_MAX, S32_MAX, S32_MAX, 0, 1'b1));
		points_pending.push_back(mk_point(CMD_RAW, FX_ONE, FX_ONE, 32'h0004_0000,
			S32_MAX, 1'b0));
		drain();

		// Extreme matrices: every entry at the top, then the bottom, then zero.
		for (int r = 0; r < HPT_NUM_REGS; r++) write_reg(4'(r), {S32_MAX, S32_MAX});
		queue_random(8);
		drain();
		for (int r = 0; r < HPT_NUM_REGS; r++) write_reg(4'(r), {S32_MIN, S32_MIN});
		queue_random(8);
		drain();
		for (int r = 0; r < HPT_NUM_REGS; r++) write_reg(4'(r), '0);
		queue_random(4);
		drain();

		// Random matrices under each idling pattern. The drain between
		// phases also makes the sender pause until all results are back.
		for (int phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int r = 0; r < HPT_NUM_REGS; r++) write_reg(4'(r), rand_pair());
			// sometimes a perspective column so the divide path is busy
			if ($urandom_range(0, 1) != 0)
				write_reg(4'd5, {FX_ONE, rand_fx()});
			queue_random(100);
			drain();
		end

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ homogeneous_point_transform.f @@
rtl/core/hpt_pkg.sv
rtl/core/hpt_if.sv
rtl/core/hpt_div_pipe.sv
rtl/core/homogeneous_point_transform.sv
rtl/core/hpt_checker.sv
sim/tb.sv
